// ===== hw/rtl/mhmq_pkg.sv =====
// Shared types and constants for the monotone hull minimum query block.
`default_nettype none
package mhmq_pkg;
    localparam int HULL_DEPTH  = 1024;
    localparam int ADDR_W      = $clog2(HULL_DEPTH);
    localparam int CNT_W       = $clog2(HULL_DEPTH + 1);
    localparam int OP_W        = 2;
    localparam int SLOPE_W     = 32;
    localparam int ICPT_W      = 64;
    localparam int TAG_W       = 20;
    localparam int X_W         = 32;
    localparam int ST_W        = 2;
    localparam int DIFF_W      = ICPT_W + 1;
    localparam int MULB_W      = SLOPE_W;
    localparam int PROD_W      = DIFF_W + MULB_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SLOPE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_INSERT,
        K_QUERY,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
        logic [TAG_W-1:0]          tag;
        logic signed [X_W-1:0]     x;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_MULW,
        S_PUSH,
        S_TAG,
        S_ANS,
        S_RESULT
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/mhmq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module mhmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mhmq_front.sv =====
// Front end: accepts transactions, decodes the op and queues them.
`default_nettype none
module mhmq_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [mhmq_pkg::OP_W-1:0]            i_op,
    input  wire logic signed [mhmq_pkg::SLOPE_W-1:0]  i_line_slope,
    input  wire logic signed [mhmq_pkg::ICPT_W-1:0]   i_line_intercept,
    input  wire logic [mhmq_pkg::TAG_W-1:0]           i_line_tag,
    input  wire logic signed [mhmq_pkg::X_W-1:0]      i_query_x,
    output logic                                      o_item_valid,
    output mhmq_pkg::t_item                           o_item,
    input  wire logic                                 i_pop
);
    mhmq_pkg::t_item                r_q [mhmq_pkg::QUEUE_DEPTH];
    logic [mhmq_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [mhmq_pkg::QPTR_W:0]      r_cnt;
    mhmq_pkg::t_item                w_item;
    logic                           w_push;

    always_comb begin
        w_item.slope     = i_line_slope;
        w_item.intercept = i_line_intercept;
        w_item.tag       = i_line_tag;
        w_item.x         = i_query_x;
        case (i_op)
            mhmq_pkg::OP_CLEAR:  w_item.kind = mhmq_pkg::K_CLEAR;
            mhmq_pkg::OP_INSERT: w_item.kind = mhmq_pkg::K_INSERT;
            mhmq_pkg::OP_QUERY:  w_item.kind = mhmq_pkg::K_QUERY;
            default:             w_item.kind = mhmq_pkg::K_NONE;
        endcase
    end

    assign o_in_ready   = r_cnt < (mhmq_pkg::QPTR_W+1)'(mhmq_pkg::QUEUE_DEPTH);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_item_valid = r_cnt != '0;
    assign o_item       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (mhmq_pkg::QPTR_W+1)'(w_push) - (mhmq_pkg::QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mhmq_mul.sv =====
// Multi-cycle signed 65 x unsigned 32 multiplier built from 32x32 partial products.
`default_nettype none
module mhmq_mul (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [mhmq_pkg::DIFF_W-1:0]  i_a,
    input  wire logic [mhmq_pkg::MULB_W-1:0]         i_b,
    output logic                                     o_done,
    output logic signed [mhmq_pkg::PROD_W-1:0]       o_prod
);
    logic [1:0]                        r_step, n_step;
    logic [mhmq_pkg::DIFF_W-1:0]       r_a;
    logic [mhmq_pkg::MULB_W-1:0]       r_b;
    logic [2*mhmq_pkg::MULB_W-1:0]     r_pp;
    logic [mhmq_pkg::PROD_W-1:0]       r_acc;

    always_comb begin
        n_step = r_step;
        if (i_start) begin
            n_step = 2'd1;
        end else if (r_step == 2'd3) begin
            n_step = 2'd0;
        end else if (r_step != 2'd0) begin
            n_step = r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            r_step <= n_step;
            o_done <= (r_step == 2'd3);
        end
    end

    // sign bit of a carries weight -2^64
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        case (r_step)
            2'd1: r_pp <= r_a[31:0] * r_b;
            2'd2: begin
                r_acc <= mhmq_pkg::PROD_W'(r_pp);
                r_pp  <= r_a[63:32] * r_b;
            end
            2'd3: r_acc <= r_acc + mhmq_pkg::PROD_W'({r_pp, 32'b0})
                         - (r_a[64] ? mhmq_pkg::PROD_W'({r_b, 64'b0}) : mhmq_pkg::PROD_W'(0));
            default: ;
        endcase
    end

    assign o_prod = $signed(r_acc);
endmodule
`default_nettype wire

// ===== hw/rtl/mhmq_back.sv =====
// Back end: envelope stack, pop test, scan pointer and result register.
`default_nettype none
module mhmq_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_item_valid,
    input  wire mhmq_pkg::t_item                 i_item,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [mhmq_pkg::TAG_W-1:0]           o_best_tag,
    output logic [mhmq_pkg::ST_W-1:0]            o_status
);
    mhmq_pkg::t_state                  r_state, n_state;
    mhmq_pkg::t_item                   r_item, n_item;
    logic [mhmq_pkg::CNT_W-1:0]        r_count, n_count, r_n, n_n;
    logic [mhmq_pkg::ADDR_W-1:0]       r_ptr, n_ptr, r_p, n_p;
    logic                              r_first, n_first;
    logic [mhmq_pkg::TAG_W-1:0]        r_res_tag, n_res_tag, n_out_tag;
    logic [mhmq_pkg::ST_W-1:0]         r_res_st, n_res_st, n_out_st;
    logic                              n_out_valid;

    logic                              w_ins, w_we, w_start, w_lt, w_le, w_done1;
    logic [mhmq_pkg::CNT_W-1:0]        w_nm1, w_nm2, w_cm1;
    logic [mhmq_pkg::ADDR_W-1:0]       w_addr_a, w_addr_b;
    logic [mhmq_pkg::CNT_W:0]          w_p1, w_p2;
    logic signed [mhmq_pkg::SLOPE_W-1:0] w_sa, w_sb;
    logic signed [mhmq_pkg::ICPT_W-1:0]  w_ia, w_ib;
    logic [mhmq_pkg::TAG_W-1:0]        w_tag_a;
    logic signed [mhmq_pkg::DIFF_W-1:0]  w_c, w_d1, w_d2, w_negx, w_dq, w_a0;
    logic signed [mhmq_pkg::SLOPE_W:0]   w_s, w_sbs, w_sas, w_sab;
    logic [mhmq_pkg::MULB_W-1:0]       w_b0;
    logic signed [mhmq_pkg::PROD_W-1:0]  w_prod0, w_prod1, w_rhs;

    assign w_ins = (r_item.kind == mhmq_pkg::K_INSERT);
    assign w_nm1 = r_n - mhmq_pkg::CNT_W'(1);
    assign w_nm2 = r_n - mhmq_pkg::CNT_W'(2);
    assign w_cm1 = r_count - mhmq_pkg::CNT_W'(1);
    assign w_p1  = (mhmq_pkg::CNT_W+1)'(r_p) + (mhmq_pkg::CNT_W+1)'(1);
    assign w_p2  = (mhmq_pkg::CNT_W+1)'(r_p) + (mhmq_pkg::CNT_W+1)'(2);
    assign w_addr_a = w_ins ? w_nm2[mhmq_pkg::ADDR_W-1:0] : r_p;
    assign w_addr_b = w_ins ? w_nm1[mhmq_pkg::ADDR_W-1:0] : w_p1[mhmq_pkg::ADDR_W-1:0];

    mhmq_ram #(.WIDTH(mhmq_pkg::SLOPE_W), .DEPTH(mhmq_pkg::HULL_DEPTH)) u_slope (
        .i_clk(i_clk), .i_we(w_we), .i_wr_addr(r_n[mhmq_pkg::ADDR_W-1:0]),
        .i_wr_data(r_item.slope), .i_rd_addr_a(w_addr_a), .i_rd_addr_b(w_addr_b),
        .o_rd_data_a(w_sa), .o_rd_data_b(w_sb)
    );
    mhmq_ram #(.WIDTH(mhmq_pkg::ICPT_W), .DEPTH(mhmq_pkg::HULL_DEPTH)) u_icpt (
        .i_clk(i_clk), .i_we(w_we), .i_wr_addr(r_n[mhmq_pkg::ADDR_W-1:0]),
        .i_wr_data(r_item.intercept), .i_rd_addr_a(w_addr_a), .i_rd_addr_b(w_addr_b),
        .o_rd_data_a(w_ia), .o_rd_data_b(w_ib)
    );
    mhmq_ram #(.WIDTH(mhmq_pkg::TAG_W), .DEPTH(mhmq_pkg::HULL_DEPTH)) u_tag (
        .i_clk(i_clk), .i_we(w_we), .i_wr_addr(r_n[mhmq_pkg::ADDR_W-1:0]),
        .i_wr_data(r_item.tag), .i_rd_addr_a(w_addr_a), .i_rd_addr_b(w_addr_b),
        .o_rd_data_a(w_tag_a), .o_rd_data_b()
    );

    // insert: lhs = (c-i1)(s2-s), rhs = (c-i2)(s1-s); query: lhs = -x(s_p - s_p+1)
    assign w_c    = mhmq_pkg::DIFF_W'(r_item.intercept);
    assign w_d1   = w_c - mhmq_pkg::DIFF_W'(w_ia);
    assign w_d2   = w_c - mhmq_pkg::DIFF_W'(w_ib);
    assign w_negx = -mhmq_pkg::DIFF_W'(r_item.x);
    assign w_dq   = mhmq_pkg::DIFF_W'(w_ia) - mhmq_pkg::DIFF_W'(w_ib);
    assign w_s    = (mhmq_pkg::SLOPE_W+1)'(r_item.slope);
    assign w_sbs  = (mhmq_pkg::SLOPE_W+1)'(w_sb) - w_s;
    assign w_sas  = (mhmq_pkg::SLOPE_W+1)'(w_sa) - w_s;
    assign w_sab  = (mhmq_pkg::SLOPE_W+1)'(w_sa) - (mhmq_pkg::SLOPE_W+1)'(w_sb);
    assign w_a0   = w_ins ? w_d1 : w_negx;
    assign w_b0   = w_ins ? w_sbs[mhmq_pkg::MULB_W-1:0] : w_sab[mhmq_pkg::MULB_W-1:0];
    assign w_rhs  = mhmq_pkg::PROD_W'(w_dq);

    mhmq_mul u_mul0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_a(w_a0), .i_b(w_b0),
        .o_done(), .o_prod(w_prod0)
    );
    mhmq_mul u_mul1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_a(w_d2),
        .i_b(w_sas[mhmq_pkg::MULB_W-1:0]), .o_done(w_done1), .o_prod(w_prod1)
    );

    assign w_lt = w_prod0 < w_prod1;
    assign w_le = w_prod0 <= w_rhs;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_n         = r_n;
        n_p         = r_p;
        n_first     = r_first;
        n_res_tag   = r_res_tag;
        n_res_st    = r_res_st;
        n_out_valid = o_out_valid && !i_out_ready;
        n_out_tag   = o_best_tag;
        n_out_st    = o_status;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_start     = 1'b0;
        case (r_state)
            mhmq_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    o_pop     = 1'b1;
                    n_item    = i_item;
                    n_res_tag = '0;
                    n_res_st  = mhmq_pkg::ST_OK;
                    n_state   = mhmq_pkg::S_RESULT;
                    case (i_item.kind)
                        mhmq_pkg::K_CLEAR: begin
                            n_count = '0;
                            n_ptr   = '0;
                        end
                        mhmq_pkg::K_INSERT: begin
                            n_n     = r_count;
                            n_first = 1'b1;
                            n_state = (r_count == '0) ? mhmq_pkg::S_PUSH : mhmq_pkg::S_FETCH;
                        end
                        mhmq_pkg::K_QUERY: begin
                            if (r_count == '0) begin
                                n_res_st = mhmq_pkg::ST_EMPTY;
                            end else begin
                                n_n = r_count;
                                if (mhmq_pkg::CNT_W'(r_ptr) >= r_count) begin
                                    n_p = w_cm1[mhmq_pkg::ADDR_W-1:0];
                                end else begin
                                    n_p = r_ptr;
                                end
                                n_state = (mhmq_pkg::CNT_W'(n_p) + mhmq_pkg::CNT_W'(1) < r_count)
                                        ? mhmq_pkg::S_FETCH : mhmq_pkg::S_TAG;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mhmq_pkg::S_FETCH: n_state = mhmq_pkg::S_EVAL;
            mhmq_pkg::S_EVAL: begin
                if (w_ins) begin
                    n_first = 1'b0;
                    if (r_first && !(w_sb > r_item.slope)) begin
                        n_res_st = mhmq_pkg::ST_SLOPE;
                        n_state  = mhmq_pkg::S_RESULT;
                    end else if (r_n < mhmq_pkg::CNT_W'(2)) begin
                        n_state = mhmq_pkg::S_PUSH;
                    end else begin
                        w_start = 1'b1;
                        n_state = mhmq_pkg::S_MULW;
                    end
                end else begin
                    w_start = 1'b1;
                    n_state = mhmq_pkg::S_MULW;
                end
            end
            mhmq_pkg::S_MULW: begin
                if (w_done1) begin
                    if (w_ins) begin
                        if (w_lt) begin
                            n_state = mhmq_pkg::S_PUSH;
                        end else begin
                            n_n     = w_nm1;
                            n_state = (w_nm1 >= mhmq_pkg::CNT_W'(2))
                                    ? mhmq_pkg::S_FETCH : mhmq_pkg::S_PUSH;
                        end
                    end else if (w_le) begin
                        n_p     = w_p1[mhmq_pkg::ADDR_W-1:0];
                        n_state = (w_p2 < (mhmq_pkg::CNT_W+1)'(r_n))
                                ? mhmq_pkg::S_FETCH : mhmq_pkg::S_TAG;
                    end else begin
                        n_state = mhmq_pkg::S_TAG;
                    end
                end
            end
            mhmq_pkg::S_PUSH: begin
                n_state = mhmq_pkg::S_RESULT;
                if (r_n >= mhmq_pkg::CNT_W'(mhmq_pkg::HULL_DEPTH)) begin
                    n_res_st = mhmq_pkg::ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_n + mhmq_pkg::CNT_W'(1);
                    if (mhmq_pkg::CNT_W'(r_ptr) > r_n) begin
                        n_ptr = r_n[mhmq_pkg::ADDR_W-1:0];
                    end
                end
            end
            mhmq_pkg::S_TAG: n_state = mhmq_pkg::S_ANS;
            mhmq_pkg::S_ANS: begin
                n_res_tag = w_tag_a;
                n_ptr     = r_p;
                n_state   = mhmq_pkg::S_RESULT;
            end
            mhmq_pkg::S_RESULT: begin
                if (!o_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_tag   = r_res_tag;
                    n_out_st    = r_res_st;
                    n_state     = mhmq_pkg::S_IDLE;
                end
            end
            default: n_state = mhmq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhmq_pkg::S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            o_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_n        <= n_n;
        r_p        <= n_p;
        r_first    <= n_first;
        r_res_tag  <= n_res_tag;
        r_res_st   <= n_res_st;
        o_best_tag <= n_out_tag;
        o_status   <= n_out_st;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mhmq_pkg::CNT_W'(mhmq_pkg::HULL_DEPTH))
        else $error("envelope count above depth");
    a_ptr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_ptr == '0)
        else $error("pointer nonzero on empty store");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> mhmq_pkg::CNT_W'(r_ptr) < r_count)
        else $error("pointer past top of envelope");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == mhmq_pkg::S_IDLE && i_item_valid)
        else $error("queue pop outside idle");
endmodule
`default_nettype wire

// ===== hw/rtl/monotone_hull_min_query.sv =====
// Clear, no-op or query on an empty store goes straight to the result register; an insert into
// an empty store is pushed at once; other inserts check the slope against the top line, then run
// pop tests while two or more lines remain; a query runs pointer tests, then reads the tag.
// A test is a RAM read, an operand step and a 65x32 multiply from 32x32 products.
// One transaction at a time: the back end takes the next one only after its result is loaded
// into the output register; a 2-entry queue accepts meanwhile.
// Reset (synchronous, active low) empties the store and the queue; the RAMs are not cleared.
`default_nettype none
module monotone_hull_min_query (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [mhmq_pkg::OP_W-1:0]           i_op,
    input  wire logic signed [mhmq_pkg::SLOPE_W-1:0] i_line_slope,
    input  wire logic signed [mhmq_pkg::ICPT_W-1:0]  i_line_intercept,
    input  wire logic [mhmq_pkg::TAG_W-1:0]          i_line_tag,
    input  wire logic signed [mhmq_pkg::X_W-1:0]     i_query_x,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [mhmq_pkg::TAG_W-1:0]               o_best_tag,
    output logic [mhmq_pkg::ST_W-1:0]                o_status
);
    logic            w_item_valid, w_pop;
    mhmq_pkg::t_item w_item;

    mhmq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_line_slope(i_line_slope), .i_line_intercept(i_line_intercept),
        .i_line_tag(i_line_tag), .i_query_x(i_query_x),
        .o_item_valid(w_item_valid), .o_item(w_item), .i_pop(w_pop)
    );

    mhmq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item_valid(w_item_valid), .i_item(w_item), .o_pop(w_pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_best_tag(o_best_tag), .o_status(o_status)
    );
endmodule
`default_nettype wire
